// ===== rtl/dead_key_composer_unit_macros.svh =====
// Assertion macros shared by the dead key composer RTL.
// Each macro expects clk and rst_n in scope.
`ifndef DEAD_KEY_COMPOSER_UNIT_MACROS_SVH
`define DEAD_KEY_COMPOSER_UNIT_MACROS_SVH

// Same-cycle implication.
`define DKC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DKC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dkc_pkg.sv =====
package dkc_pkg;

  // Dead key codes.
  localparam logic [7:0] DK_TILDE  = 8'd126;
  localparam logic [7:0] DK_GRAVE  = 8'd96;
  localparam logic [7:0] DK_DQUOTE = 8'd34;
  localparam logic [7:0] DK_SQUOTE = 8'd39;
  localparam logic [7:0] DK_CARET  = 8'd94;
  localparam logic [7:0] DK_DIAER  = 8'd168;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_NONE   = 8'd0;

  // Result kinds.
  localparam logic [1:0] KIND_PRESS   = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_FINAL   = 2'd2;

  // Queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // One classified keystroke: an optional flushed dead key and the final code.
  typedef struct packed {
    logic       flush;
    logic [7:0] dead_code;
    logic [7:0] final_code;
  } dkc_entry_t;

  function automatic logic is_dead(input logic [7:0] c);
    return c inside {DK_TILDE, DK_GRAVE, DK_DQUOTE, DK_SQUOTE, DK_CARET, DK_DIAER};
  endfunction

  // Lowercase composition; zero when the pair has no entry.
  function automatic logic [7:0] compose_lower(input logic [7:0] dk, input logic [7:0] c);
    logic [7:0] r;
    r = CH_NONE;
    case (dk)
      DK_TILDE: begin
        case (c)
          8'd97:   r = 8'd227; // a
          8'd110:  r = 8'd241; // n
          8'd111:  r = 8'd245; // o
          default: r = CH_NONE;
        endcase
      end
      DK_GRAVE: begin
        case (c)
          8'd97:   r = 8'd224;
          8'd101:  r = 8'd232;
          8'd105:  r = 8'd236;
          8'd111:  r = 8'd242;
          8'd117:  r = 8'd249;
          default: r = CH_NONE;
        endcase
      end
      DK_SQUOTE: begin
        case (c)
          8'd97:   r = 8'd225;
          8'd101:  r = 8'd233;
          8'd105:  r = 8'd237;
          8'd111:  r = 8'd243;
          8'd117:  r = 8'd250;
          default: r = CH_NONE;
        endcase
      end
      DK_DQUOTE, DK_DIAER: begin
        case (c)
          8'd97:   r = 8'd228;
          8'd101:  r = 8'd235;
          8'd105:  r = 8'd239;
          8'd111:  r = 8'd246;
          8'd117:  r = 8'd252;
          8'd121:  r = 8'd255; // y
          default: r = CH_NONE;
        endcase
      end
      DK_CARET: begin
        case (c)
          8'd97:   r = 8'd226;
          8'd101:  r = 8'd234;
          8'd105:  r = 8'd238;
          8'd111:  r = 8'd244;
          8'd117:  r = 8'd251;
          default: r = CH_NONE;
        endcase
      end
      default: r = CH_NONE;
    endcase
    return r;
  endfunction

  // Full composition; capitals map to capital forms, capital Y has none.
  function automatic logic [7:0] compose(input logic [7:0] dk, input logic [7:0] c);
    logic [7:0] r;
    r = CH_NONE;
    if (c inside {[8'd65:8'd90]}) begin
      if (c != 8'd89) begin
        r = compose_lower(dk, c + 8'd32);
        if (r != CH_NONE) begin
          r = r - 8'd32;
        end
      end
    end else begin
      r = compose_lower(dk, c);
    end
    return r;
  endfunction

endpackage

// ===== rtl/dkc_front.sv =====
module dkc_front
  import dkc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_in,
  input  logic       q_full,
  output logic       q_push,
  output dkc_entry_t q_entry
);

  `include "dead_key_composer_unit_macros.svh"

  logic [7:0] pending_r;
  logic [7:0] pending_nxt;
  logic [7:0] hit;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign hit      = compose(pending_r, in_char_in);

  // Classify the keystroke against the pending dead key.
  always_comb begin
    pending_nxt          = pending_r;
    q_entry.flush        = 1'b0;
    q_entry.dead_code    = pending_r;
    q_entry.final_code   = in_char_in;
    if (is_dead(in_char_in)) begin
      if (pending_r != CH_NONE) begin
        q_entry.flush = 1'b1;
        pending_nxt   = CH_NONE;
      end else begin
        pending_nxt        = in_char_in;
        q_entry.final_code = CH_NONE;
      end
    end else if (pending_r != CH_NONE && in_char_in != CH_NONE) begin
      pending_nxt = CH_NONE;
      if (hit != CH_NONE) begin
        q_entry.final_code = hit;
      end else begin
        q_entry.flush      = 1'b1;
        q_entry.final_code = (in_char_in == CH_SPACE) ? CH_NONE : in_char_in;
      end
    end
  end

  // Pending dead key updates on every transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= CH_NONE;
    end else if (q_push) begin
      pending_r <= pending_nxt;
    end
  end

  `DKC_ASSERT_NOW(a_pending_is_dead, pending_r != CH_NONE, is_dead(pending_r), "pending key is not a dead key")
  `DKC_ASSERT_NOW(a_flush_has_key, q_push && q_entry.flush, pending_r != CH_NONE, "flush without a pending key")
  `DKC_ASSERT_NEXT(a_flush_clears, q_push && q_entry.flush, pending_r == CH_NONE, "pending key kept after flush")

endmodule

// ===== rtl/dkc_queue.sv =====
module dkc_queue
  import dkc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  dkc_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output dkc_entry_t head_entry
);

  `include "dead_key_composer_unit_macros.svh"

  dkc_entry_t           slot_r [QDEPTH];
  logic [QAW-1:0]       wr_ptr_r;
  logic [QAW-1:0]       rd_ptr_r;
  logic [QCW-1:0]       count_r;

  assign full       = (count_r == QCW'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = slot_r[rd_ptr_r];

  // Entry storage; no reset needed.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `DKC_ASSERT_NOW(a_no_overflow, push, !full || pop, "push into a full queue")
  `DKC_ASSERT_NOW(a_no_underflow, pop, head_valid, "pop from an empty queue")

endmodule

// ===== rtl/dkc_back.sv =====
module dkc_back
  import dkc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  dkc_entry_t head_entry,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_code_out,
  output logic [1:0] out_kind,
  output logic       out_last
);

  `include "dead_key_composer_unit_macros.svh"

  typedef enum logic [1:0] {
    PH_PRESS,
    PH_RELEASE,
    PH_FINAL
  } phase_t;

  phase_t     phase_r;
  logic       out_valid_r;
  logic [7:0] out_code_r;
  logic [1:0] out_kind_r;
  logic       out_last_r;
  logic       load;

  // The output register takes a new item when empty or being drained.
  assign load = head_valid && (!out_valid_r || out_ready);
  assign pop  = load && (phase_r == PH_FINAL || !head_entry.flush);

  assign out_valid    = out_valid_r;
  assign out_code_out = out_code_r;
  assign out_kind     = out_kind_r;
  assign out_last     = out_last_r;

  // Step through press, release and final for a flushed head entry; other entries give only the final.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_PRESS;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (load) begin
        out_valid_r <= 1'b1;
        case (phase_r)
          PH_PRESS: begin
            if (head_entry.flush) begin
              out_code_r <= head_entry.dead_code;
              out_kind_r <= KIND_PRESS;
              out_last_r <= 1'b0;
              phase_r    <= PH_RELEASE;
            end else begin
              out_code_r <= head_entry.final_code;
              out_kind_r <= KIND_FINAL;
              out_last_r <= 1'b1;
            end
          end
          PH_RELEASE: begin
            out_code_r <= head_entry.dead_code;
            out_kind_r <= KIND_RELEASE;
            out_last_r <= 1'b0;
            phase_r    <= PH_FINAL;
          end
          default: begin
            out_code_r <= head_entry.final_code;
            out_kind_r <= KIND_FINAL;
            out_last_r <= 1'b1;
            phase_r    <= PH_PRESS;
          end
        endcase
      end
    end
  end

  `DKC_ASSERT_NOW(a_mid_flush_head, phase_r != PH_PRESS, head_valid, "flush in progress without an entry")
  `DKC_ASSERT_NEXT(a_press_then_release, out_valid && out_ready && out_kind == KIND_PRESS, out_valid && out_kind == KIND_RELEASE, "press not followed by release")
  `DKC_ASSERT_NEXT(a_release_then_final, out_valid && out_ready && out_kind == KIND_RELEASE, out_valid && out_kind == KIND_FINAL && out_last, "release not followed by final")

endmodule

// ===== rtl/dead_key_composer_unit.sv =====
// Each input transfer is registered in the queue and then in the output register.
// The output register gives one result transfer per cycle while out_ready is high and an
// entry waits; an input yields one result, or three when a dead key is flushed.
// A two-entry queue lets input transfers continue while results drain.
// Reset (rst_n low, synchronous) clears the pending dead key, the queue and the output.
module dead_key_composer_unit
  import dkc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_code_out,
  output logic [1:0] out_kind,
  output logic       out_last
);

  logic       q_full;
  logic       q_push;
  logic       q_pop;
  logic       q_head_valid;
  dkc_entry_t q_push_entry;
  dkc_entry_t q_head_entry;

  // Classification and pending dead key.
  dkc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_char_in (in_char_in),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (q_push_entry)
  );

  // Decoupling queue.
  dkc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_entry (q_head_entry)
  );

  // Result sequencing and output register.
  dkc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (q_head_valid),
    .head_entry   (q_head_entry),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_code_out (out_code_out),
    .out_kind     (out_kind),
    .out_last     (out_last)
  );

endmodule
